### sv/chm_pkg.sv
`timescale 1ns / 1ps
package chm_pkg;

  localparam int KEY_W     = 64;
  localparam int HASH_W    = 32;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 9;
  localparam int DIV_STEPS = 16;
  localparam int QDEPTH    = 2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_GET,
    CMD_REMOVE,
    CMD_ITER
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_UPDATED,
    ST_FOUND,
    ST_NOTFOUND,
    ST_FULL,
    ST_REMOVED,
    ST_ENTRY,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   hash;
    logic [VAL_W-1:0]    value;
  } req_t;

  typedef struct packed {
    logic clearing;
    logic empty;
  } back_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_HEAD_RD,
    B_HEAD_WAIT,
    B_WALK_RD,
    B_WALK_CHK,
    B_UPD,
    B_RM1,
    B_RM2,
    B_ALLOC_RD,
    B_ALLOC_WAIT,
    B_INS1,
    B_INS2,
    B_ITER_RD,
    B_ITER_EMIT,
    B_EMIT
  } back_state_t;

endpackage

### sv/chained_hash_map_engine.sv
`timescale 1ns / 1ps
// Key-value map with separate chaining over a fixed pool of NODES nodes.
// Requests enter on the s_ stream: s_tuser is the command (add, get, remove,
// iterate) and s_tdata carries key, key hash and value. Results leave on the
// m_ stream: m_tuser is the status, m_tdata carries key, value, entry count
// and longest chain seen, and m_tlast marks the final result of a request.
// The bucket count is written on the cfg_ channel; it takes effect only while
// the map is empty and is clamped to 1..BUCKETS.
// A front stage takes one item, reduces the hash modulo the bucket count two
// bits per cycle and queues it; it takes no new item before that one is queued.
// On its way to a result an item passes the division in the front, the queue,
// the read of the bucket head, a visit to each chain node, the end-of-chain
// check, for an add the node allocation and link writes, and the loading of
// the result register. Iterate gives one result per stored entry, or a single
// one when the map is empty. The front accepts the next item while the back
// is still working. After reset the back clears the bucket head memory, one
// bucket per cycle, and no item is accepted until that pass ends. When the
// receiver holds m_tready low the result register holds, the back waits and
// the queue and front fill up before s_tready drops.
module chained_hash_map_engine #(
  parameter int NODES   = 64,
  parameter int BUCKETS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // key[63:0], key_hash[95:64], value[159:96]
  input  logic [1:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // out_key, out_value, entry_count, longest_chain_seen
  output logic [2:0]   m_tuser,   // status
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data   // bucket_count
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int QW = BW + $bits(chm_pkg::req_t);

  chm_pkg::back_stat_t stat;
  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  chm_front #(.BUCKETS(BUCKETS), .BW(BW), .CW(CW)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .cfg_valid, .cfg_ready, .cfg_data, .stat,
    .q_push, .q_data(q_in), .q_full);

  chm_fifo #(.W(QW), .DEPTH(chm_pkg::QDEPTH)) u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head_data(q_out));

  chm_back #(.NODES(NODES), .BUCKETS(BUCKETS), .BW(BW)) u_back (
    .clk, .rst, .q_valid, .q_data(q_out), .q_pop, .stat,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast);

endmodule

### sv/chm_ram.sv
`timescale 1ns / 1ps
module chm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/chm_fifo.sv
`timescale 1ns / 1ps
module chm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head_data
);

  localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW = $clog2(DEPTH + 1);

  logic [W-1:0]   slots [DEPTH];
  logic [PTW-1:0] wr_ptr;
  logic [PTW-1:0] rd_ptr;
  logic [CTW-1:0] fill;

  assign full      = (fill == CTW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PTW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CTW'(push && !full) - CTW'(pop && not_empty);
    end
  end

endmodule

### sv/chm_front.sv
`timescale 1ns / 1ps
module chm_front #(
  parameter int BUCKETS = 256,
  parameter int BW      = 8,
  parameter int CW      = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [159:0]                    s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chm_pkg::CFG_W-1:0]       cfg_data,
  input  chm_pkg::back_stat_t             stat,
  output logic                            q_push,
  output logic [BW+$bits(chm_pkg::req_t)-1:0] q_data,
  input  logic                            q_full
);

  localparam int SW = $clog2(chm_pkg::DIV_STEPS);

  chm_pkg::front_state_t state, state_next;
  chm_pkg::req_t         req;
  logic [chm_pkg::HASH_W-1:0] hsh;
  logic [CW:0]           rem;
  logic [CW:0]           r1, r2;
  logic [SW-1:0]         steps;
  logic [CW-1:0]         bc;

  // Two restoring steps of hash mod bucket count per cycle, MSB first.
  always_comb begin
    r1 = {rem[CW-1:0], hsh[chm_pkg::HASH_W-1]};
    if (r1 >= {1'b0, bc}) begin
      r1 = r1 - {1'b0, bc};
    end
    r2 = {r1[CW-1:0], hsh[chm_pkg::HASH_W-2]};
    if (r2 >= {1'b0, bc}) begin
      r2 = r2 - {1'b0, bc};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      chm_pkg::F_IDLE: begin
        if (s_tvalid && s_tready) state_next = chm_pkg::F_DIV;
      end
      chm_pkg::F_DIV: begin
        if (steps == SW'(chm_pkg::DIV_STEPS - 1)) state_next = chm_pkg::F_PUSH;
      end
      chm_pkg::F_PUSH: begin
        if (!q_full) state_next = chm_pkg::F_IDLE;
      end
      default: state_next = chm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == chm_pkg::F_IDLE) && !stat.clearing;
    q_push   = (state == chm_pkg::F_PUSH) && !q_full;
  end

  assign cfg_ready = 1'b1;
  assign q_data    = {rem[BW-1:0], req};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chm_pkg::F_IDLE;
      bc    <= CW'((61 > BUCKETS) ? BUCKETS : 61);
    end else begin
      state <= state_next;
      // The bucket count only changes while the map holds nothing.
      if (cfg_valid && stat.empty) begin
        if (cfg_data == '0) begin
          bc <= CW'(1);
        end else if (32'(cfg_data) > 32'(BUCKETS)) begin
          bc <= CW'(BUCKETS);
        end else begin
          bc <= CW'(cfg_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == chm_pkg::F_IDLE && s_tvalid && s_tready) begin
      req.cmd   <= chm_pkg::cmd_t'(s_tuser);
      req.key   <= s_tdata[63:0];
      req.hash  <= s_tdata[95:64];
      req.value <= s_tdata[159:96];
      hsh       <= s_tdata[95:64];
      rem       <= '0;
      steps     <= '0;
    end else if (state == chm_pkg::F_DIV) begin
      rem   <= r2;
      hsh   <= {hsh[chm_pkg::HASH_W-3:0], 2'b00};
      steps <= steps + 1'b1;
    end
  end

endmodule

### sv/chm_back.sv
`timescale 1ns / 1ps
module chm_back #(
  parameter int NODES   = 64,
  parameter int BUCKETS = 256,
  parameter int BW      = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  logic [BW+$bits(chm_pkg::req_t)-1:0] q_data,
  output logic                                q_pop,
  output chm_pkg::back_stat_t                 stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [143:0]                        m_tdata,
  output logic [2:0]                          m_tuser,
  output logic                                m_tlast
);

  localparam int AW = $clog2(NODES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NIL  = PW'(NODES);

  chm_pkg::back_state_t state, state_next;
  chm_pkg::req_t        q_req, req;
  logic [BW-1:0]        q_bkt, b_q, clr;

  logic [PW-1:0] p, prev, len, head_q, cn_q, on_q, op_q;
  logic [PW-1:0] free_head, fresh, count, record, order_first, order_last;
  chm_pkg::status_t res_status;
  logic [chm_pkg::VAL_W-1:0] res_value;

  chm_pkg::status_t m_status;
  logic [chm_pkg::KEY_W-1:0] m_key;
  logic [chm_pkg::VAL_W-1:0] m_value;
  logic [PW-1:0] m_count, m_longest;

  // memory ports
  logic bh_we, key_we, val_we, hash_we, cn_we, on_we, op_we;
  logic [BW-1:0] bh_waddr;
  logic [PW-1:0] bh_wdata, bh_rdata;
  logic [AW-1:0] cn_waddr, on_waddr, op_waddr, nd_raddr;
  logic [PW-1:0] cn_wdata, on_wdata, op_wdata, cn_rdata, on_rdata, op_rdata;
  logic [chm_pkg::KEY_W-1:0]  key_rdata;
  logic [chm_pkg::VAL_W-1:0]  val_rdata;
  logic [chm_pkg::HASH_W-1:0] hash_rdata;

  logic hit, slot_free, load_out;

  assign {q_bkt, q_req} = q_data;
  assign nd_raddr  = p[AW-1:0];
  assign hit       = (hash_rdata == req.hash) && (key_rdata == req.key);
  assign slot_free = !m_tvalid || m_tready;

  chm_ram #(.W(PW), .DEPTH(BUCKETS)) u_bucket_head (
    .clk, .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata), .raddr(b_q), .rdata(bh_rdata));
  chm_ram #(.W(chm_pkg::KEY_W), .DEPTH(NODES)) u_node_key (
    .clk, .we(key_we), .waddr(p[AW-1:0]), .wdata(req.key), .raddr(nd_raddr),
    .rdata(key_rdata));
  chm_ram #(.W(chm_pkg::VAL_W), .DEPTH(NODES)) u_node_value (
    .clk, .we(val_we), .waddr(p[AW-1:0]), .wdata(req.value), .raddr(nd_raddr),
    .rdata(val_rdata));
  chm_ram #(.W(chm_pkg::HASH_W), .DEPTH(NODES)) u_node_hash (
    .clk, .we(hash_we), .waddr(p[AW-1:0]), .wdata(req.hash), .raddr(nd_raddr),
    .rdata(hash_rdata));
  chm_ram #(.W(PW), .DEPTH(NODES)) u_chain_next (
    .clk, .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata), .raddr(nd_raddr),
    .rdata(cn_rdata));
  chm_ram #(.W(PW), .DEPTH(NODES)) u_order_next (
    .clk, .we(on_we), .waddr(on_waddr), .wdata(on_wdata), .raddr(nd_raddr),
    .rdata(on_rdata));
  chm_ram #(.W(PW), .DEPTH(NODES)) u_order_prev (
    .clk, .we(op_we), .waddr(op_waddr), .wdata(op_wdata), .raddr(nd_raddr),
    .rdata(op_rdata));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      chm_pkg::B_CLEAR: begin
        if (clr == BW'(BUCKETS - 1)) state_next = chm_pkg::B_IDLE;
      end
      chm_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_req.cmd == chm_pkg::CMD_ITER) begin
            state_next = (order_first < NIL) ? chm_pkg::B_ITER_RD : chm_pkg::B_EMIT;
          end else begin
            state_next = chm_pkg::B_HEAD_RD;
          end
        end
      end
      chm_pkg::B_HEAD_RD:    state_next = chm_pkg::B_HEAD_WAIT;
      chm_pkg::B_HEAD_WAIT:  state_next = chm_pkg::B_WALK_RD;
      chm_pkg::B_WALK_RD: begin
        if (p < NIL) begin
          state_next = chm_pkg::B_WALK_CHK;
        end else if (req.cmd == chm_pkg::CMD_ADD && free_head < NIL) begin
          state_next = chm_pkg::B_ALLOC_RD;
        end else if (req.cmd == chm_pkg::CMD_ADD && fresh < NIL) begin
          state_next = chm_pkg::B_INS1;
        end else begin
          state_next = chm_pkg::B_EMIT;
        end
      end
      chm_pkg::B_WALK_CHK: begin
        if (!hit) begin
          state_next = chm_pkg::B_WALK_RD;
        end else begin
          case (req.cmd)
            chm_pkg::CMD_ADD:    state_next = chm_pkg::B_UPD;
            chm_pkg::CMD_REMOVE: state_next = chm_pkg::B_RM1;
            default:             state_next = chm_pkg::B_EMIT;
          endcase
        end
      end
      chm_pkg::B_UPD:        state_next = chm_pkg::B_EMIT;
      chm_pkg::B_RM1:        state_next = chm_pkg::B_RM2;
      chm_pkg::B_RM2:        state_next = chm_pkg::B_EMIT;
      chm_pkg::B_ALLOC_RD:   state_next = chm_pkg::B_ALLOC_WAIT;
      chm_pkg::B_ALLOC_WAIT: state_next = chm_pkg::B_INS1;
      chm_pkg::B_INS1:       state_next = chm_pkg::B_INS2;
      chm_pkg::B_INS2:       state_next = chm_pkg::B_EMIT;
      chm_pkg::B_ITER_RD:    state_next = chm_pkg::B_ITER_EMIT;
      chm_pkg::B_ITER_EMIT: begin
        if (slot_free) begin
          state_next = (on_rdata < NIL) ? chm_pkg::B_ITER_RD : chm_pkg::B_IDLE;
        end
      end
      chm_pkg::B_EMIT: begin
        if (slot_free) state_next = chm_pkg::B_IDLE;
      end
      default: state_next = chm_pkg::B_IDLE;
    endcase
  end

  // Memory write controls, queue pop and output load.
  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = b_q;
    bh_wdata = NIL;
    key_we   = 1'b0;
    val_we   = 1'b0;
    hash_we  = 1'b0;
    cn_we    = 1'b0;
    cn_waddr = p[AW-1:0];
    cn_wdata = free_head;
    on_we    = 1'b0;
    on_waddr = p[AW-1:0];
    on_wdata = NIL;
    op_we    = 1'b0;
    op_waddr = p[AW-1:0];
    op_wdata = order_last;
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      chm_pkg::B_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr;
      end
      chm_pkg::B_IDLE: q_pop = q_valid;
      chm_pkg::B_UPD:  val_we = 1'b1;
      chm_pkg::B_RM1: begin
        if (prev < NIL) begin
          cn_we    = 1'b1;
          cn_waddr = prev[AW-1:0];
          cn_wdata = cn_q;
        end else begin
          bh_we    = 1'b1;
          bh_wdata = cn_q;
        end
        if (on_q < NIL) begin
          op_we    = 1'b1;
          op_waddr = on_q[AW-1:0];
          op_wdata = op_q;
        end
        if (op_q < NIL) begin
          on_we    = 1'b1;
          on_waddr = op_q[AW-1:0];
          on_wdata = on_q;
        end
      end
      chm_pkg::B_RM2: cn_we = 1'b1;
      chm_pkg::B_INS1: begin
        key_we   = 1'b1;
        val_we   = 1'b1;
        hash_we  = 1'b1;
        cn_we    = 1'b1;
        cn_wdata = head_q;
        bh_we    = 1'b1;
        bh_wdata = p;
        op_we    = 1'b1;
        on_we    = 1'b1;
      end
      chm_pkg::B_INS2: begin
        if (order_last < NIL) begin
          on_we    = 1'b1;
          on_waddr = order_last[AW-1:0];
          on_wdata = p;
        end
      end
      chm_pkg::B_ITER_EMIT: load_out = slot_free;
      chm_pkg::B_EMIT:      load_out = slot_free;
      default: ;
    endcase
  end

  assign stat.clearing = (state == chm_pkg::B_CLEAR);
  assign stat.empty    = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= chm_pkg::B_CLEAR;
      clr         <= '0;
      free_head   <= NIL;
      fresh       <= '0;
      count       <= '0;
      record      <= '0;
      order_first <= NIL;
      order_last  <= NIL;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == chm_pkg::B_CLEAR) clr <= clr + 1'b1;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        chm_pkg::B_WALK_RD: begin
          if (!(p < NIL) && req.cmd == chm_pkg::CMD_ADD && !(free_head < NIL)
              && fresh < NIL) begin
            fresh <= fresh + 1'b1;
          end
        end
        chm_pkg::B_ALLOC_WAIT: free_head <= cn_rdata;
        chm_pkg::B_RM1: begin
          if (order_first == p) order_first <= on_q;
          if (order_last == p) order_last <= op_q;
          if (count != '0) count <= count - 1'b1;
        end
        chm_pkg::B_RM2: free_head <= p;
        chm_pkg::B_INS1: begin
          if (count < NIL) count <= count + 1'b1;
          if (len > record) record <= (len > NIL) ? NIL : len;
        end
        chm_pkg::B_INS2: begin
          order_last <= p;
          if (!(order_first < NIL)) order_first <= p;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      chm_pkg::B_IDLE: begin
        if (q_valid) begin
          req        <= q_req;
          b_q        <= q_bkt;
          prev       <= NIL;
          len        <= PW'(1);
          p          <= order_first;
          res_status <= chm_pkg::ST_EMPTY;
          res_value  <= '0;
        end
      end
      chm_pkg::B_HEAD_WAIT: begin
        p      <= bh_rdata;
        head_q <= bh_rdata;
      end
      chm_pkg::B_WALK_RD: begin
        if (!(p < NIL)) begin
          res_value <= '0;
          if (req.cmd != chm_pkg::CMD_ADD) begin
            res_status <= chm_pkg::ST_NOTFOUND;
          end else if (free_head < NIL) begin
            p <= free_head;
          end else if (fresh < NIL) begin
            p <= fresh;
          end else begin
            res_status <= chm_pkg::ST_FULL;
          end
        end
      end
      chm_pkg::B_WALK_CHK: begin
        if (hit) begin
          cn_q <= cn_rdata;
          on_q <= on_rdata;
          op_q <= op_rdata;
          case (req.cmd)
            chm_pkg::CMD_ADD: begin
              res_status <= chm_pkg::ST_UPDATED;
              res_value  <= '0;
            end
            chm_pkg::CMD_REMOVE: begin
              res_status <= chm_pkg::ST_REMOVED;
              res_value  <= val_rdata;
            end
            default: begin
              res_status <= chm_pkg::ST_FOUND;
              res_value  <= val_rdata;
            end
          endcase
        end else begin
          prev <= p;
          p    <= cn_rdata;
          len  <= len + 1'b1;
        end
      end
      chm_pkg::B_INS1: begin
        res_status <= chm_pkg::ST_INSERTED;
        res_value  <= '0;
      end
      chm_pkg::B_ITER_EMIT: begin
        if (slot_free) p <= on_rdata;
      end
      default: ;
    endcase
  end

  // Output register: counts are sampled after the item's own updates.
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_count   <= count;
      m_longest <= record;
      if (state == chm_pkg::B_ITER_EMIT) begin
        m_status <= chm_pkg::ST_ENTRY;
        m_key    <= key_rdata;
        m_value  <= val_rdata;
        m_tlast  <= !(on_rdata < NIL);
      end else begin
        m_status <= res_status;
        m_key    <= req.key;
        m_value  <= res_value;
        m_tlast  <= 1'b1;
      end
    end
  end

  assign m_tuser = m_status;
  assign m_tdata = {2'b00, chm_pkg::CNT_W'(m_longest), chm_pkg::CNT_W'(m_count),
                    m_value, m_key};

  a_count_le_fresh: assert property (@(posedge clk) disable iff (rst)
    count <= fresh) else $error("entry count exceeds nodes handed out");
  a_clear_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == chm_pkg::B_CLEAR) |-> !m_tvalid) else $error("result during clearing pass");
  a_record_bound: assert property (@(posedge clk) disable iff (rst)
    record <= NIL) else $error("chain record out of range");
  a_ins_node: assert property (@(posedge clk) disable iff (rst)
    (state == chm_pkg::B_INS1) |-> (p < NIL)) else $error("insert without a node");
  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (state == chm_pkg::B_RM2) |=> (free_head == $past(p)))
    else $error("removed node not on free list");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int POOL = 64;
  localparam int NIL = POOL;
  localparam int NB = 256;
  localparam int SETTLE = 200;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    chm_pkg::status_t status;
    logic [63:0]      key;
    logic [63:0]      value;
    logic [6:0]       count;
    logic [6:0]       longest;
    logic             last;
  } map_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [8:0]   cfg_data;

  chained_hash_map_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Mirror of the map state.
  int          buckets_used;
  int          bucket_head [NB];
  logic [63:0] node_key    [POOL];
  logic [63:0] node_value  [POOL];
  logic [31:0] node_hash   [POOL];
  int          chain_next  [POOL];
  int          order_next  [POOL];
  int          order_prev  [POOL];
  int          order_first, order_last, free_head, fresh_count, stored, chain_record;

  chm_pkg::req_t pending_reqs[$];
  map_result_t   expected_results[$];
  chm_pkg::req_t drv_item;
  bit            drive_busy, item_taken, result_taken, burst_mode;
  int            sender_gap, receiver_stall, idle_cycles, failures;

  logic [63:0] pool_key  [16];
  logic [31:0] pool_hash [16];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void expect_result(chm_pkg::status_t st, logic [63:0] k,
                                        logic [63:0] v, bit lst);
    map_result_t r;
    r.status = st;
    r.key = k;
    r.value = v;
    r.count = stored[6:0];
    r.longest = chain_record[6:0];
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void map_reset();
    buckets_used = 61;
    foreach (bucket_head[i]) bucket_head[i] = NIL;
    order_first = NIL;
    order_last = NIL;
    free_head = NIL;
    fresh_count = 0;
    stored = 0;
    chain_record = 0;
  endfunction

  function automatic void map_set_buckets(logic [8:0] v);
    if (stored == 0) buckets_used = (v == 0) ? 1 : (v > NB) ? NB : int'(v);
  endfunction

  function automatic void map_predict(chm_pkg::req_t rq);
    int b, p, prev, len, steps, n, k;
    bit hit;
    b = int'(rq.hash % buckets_used);
    if (rq.cmd == chm_pkg::CMD_ITER) begin
      p = order_first;
      k = 0;
      if (p >= POOL) begin
        expect_result(chm_pkg::ST_EMPTY, rq.key, '0, 1'b1);
        return;
      end
      while (p < POOL && k < POOL) begin
        k++;
        expect_result(chm_pkg::ST_ENTRY, node_key[p], node_value[p],
                      !(order_next[p] < POOL && k < POOL));
        p = order_next[p];
      end
      return;
    end
    p = bucket_head[b];
    prev = NIL;
    len = 1;
    steps = 0;
    while (p < POOL && steps < POOL) begin
      if (node_hash[p] == rq.hash && node_key[p] == rq.key) break;
      prev = p;
      p = chain_next[p];
      len++;
      steps++;
    end
    hit = p < POOL && steps < POOL;
    case (rq.cmd)
      chm_pkg::CMD_GET: begin
        if (hit) expect_result(chm_pkg::ST_FOUND, rq.key, node_value[p], 1'b1);
        else expect_result(chm_pkg::ST_NOTFOUND, rq.key, '0, 1'b1);
      end
      chm_pkg::CMD_REMOVE: begin
        if (!hit) begin
          expect_result(chm_pkg::ST_NOTFOUND, rq.key, '0, 1'b1);
          return;
        end
        if (prev < POOL) chain_next[prev] = chain_next[p];
        else bucket_head[b] = chain_next[p];
        if (order_first == p) order_first = order_next[p];
        if (order_last == p) order_last = order_prev[p];
        if (order_next[p] < POOL) order_prev[order_next[p]] = order_prev[p];
        if (order_prev[p] < POOL) order_next[order_prev[p]] = order_next[p];
        if (stored > 0) stored--;
        chain_next[p] = free_head;
        free_head = p;
        expect_result(chm_pkg::ST_REMOVED, rq.key, node_value[p], 1'b1);
      end
      default: begin
        if (hit) begin
          node_value[p] = rq.value;
          expect_result(chm_pkg::ST_UPDATED, rq.key, '0, 1'b1);
          return;
        end
        if (free_head < POOL) begin
          n = free_head;
          free_head = chain_next[n];
        end else if (fresh_count < POOL) begin
          n = fresh_count;
          fresh_count++;
        end else begin
          expect_result(chm_pkg::ST_FULL, rq.key, '0, 1'b1);
          return;
        end
        node_key[n] = rq.key;
        node_value[n] = rq.value;
        node_hash[n] = rq.hash;
        chain_next[n] = bucket_head[b];
        bucket_head[b] = n;
        order_prev[n] = order_last;
        order_next[n] = NIL;
        if (order_last < POOL) order_next[order_last] = n;
        if (order_first >= POOL) order_first = n;
        order_last = n;
        if (stored < POOL) stored++;
        if (len > chain_record) chain_record = (len > POOL) ? POOL : len;
        expect_result(chm_pkg::ST_INSERTED, rq.key, '0, 1'b1);
      end
    endcase
  endfunction

  // Sender: one request per handshake, random gap after each item unless in burst mode.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      map_predict(drv_item);
      item_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (item_taken) begin
      item_taken = 0;
      drive_busy = 0;
    end
    if (!drive_busy) begin
      if (sender_gap > 0) begin
        sender_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drv_item = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= drv_item.cmd;
        s_tdata <= {drv_item.value, drv_item.hash, drv_item.key};
        drive_busy = 1;
        sender_gap = burst_mode ? 0 : $urandom_range(0, 17);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: compares each result with the oldest expectation.
  always @(posedge clk) begin
    map_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      result_taken = 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d key %h", m_tuser, m_tdata[63:0]);
        failures++;
      end else begin
        e = expected_results.pop_front();
        if (m_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_tuser);
          failures++;
        end
        if (m_tdata[63:0] !== e.key) begin
          $error("out_key: expected %h, got %h", e.key, m_tdata[63:0]);
          failures++;
        end
        if (m_tdata[127:64] !== e.value) begin
          $error("out_value: expected %h, got %h", e.value, m_tdata[127:64]);
          failures++;
        end
        if (m_tdata[134:128] !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, m_tdata[134:128]);
          failures++;
        end
        if (m_tdata[141:135] !== e.longest) begin
          $error("longest_chain_seen: expected %0d, got %0d", e.longest, m_tdata[141:135]);
          failures++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_tlast);
          failures++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 0;
      receiver_stall = burst_mode ? 0 : $urandom_range(0, 17);
    end
    if (receiver_stall > 0) begin
      receiver_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || drive_busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_buckets(logic [8:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    map_set_buckets(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_req(chm_pkg::cmd_t c, logic [63:0] k, logic [31:0] h,
                          logic [63:0] v);
    chm_pkg::req_t rq;
    rq.cmd = c;
    rq.key = k;
    rq.hash = h;
    rq.value = v;
    pending_reqs.push_back(rq);
  endtask

  // Queues a remove for every stored entry, leaving the map empty.
  task automatic drain_map();
    int p;
    p = order_first;
    while (p < POOL) begin
      push_req(chm_pkg::CMD_REMOVE, node_key[p], node_hash[p], {$urandom, $urandom});
      p = order_next[p];
    end
    wait_idle();
  endtask

  task automatic random_reqs(int count);
    int i, j;
    chm_pkg::cmd_t c;
    logic [31:0] h;
    for (i = 0; i < count; i++) begin
      j = $urandom_range(0, 15);
      case ($urandom_range(0, 19)) inside
        [0:7]:   c = chm_pkg::CMD_ADD;
        [8:12]:  c = chm_pkg::CMD_GET;
        [13:17]: c = chm_pkg::CMD_REMOVE;
        default: c = chm_pkg::CMD_ITER;
      endcase
      // Mostly keys from the pool with their own hash, so lookups hit.
      h = ($urandom_range(0, 19) == 0) ? $urandom : pool_hash[j];
      if ($urandom_range(0, 9) == 0)
        push_req(c, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
      else push_req(c, pool_key[j], h, {$urandom, $urandom});
    end
  endtask

  task automatic new_pool();
    foreach (pool_key[i]) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = $urandom;
    end
  endtask

  initial begin
    int i;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = chm_pkg::CMD_ADD;
    m_tready = 0;
    cfg_valid = 0;
    cfg_data = '0;
    failures = 0;
    idle_cycles = 0;
    burst_mode = 0;
    map_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty map, field extremes, update, hash mismatch, remove twice.
    push_req(chm_pkg::CMD_ITER, '1, '1, '1);
    push_req(chm_pkg::CMD_GET, 64'h0, 32'h0, '0);
    push_req(chm_pkg::CMD_REMOVE, '1, '1, '0);
    push_req(chm_pkg::CMD_ADD, 64'h0, 32'h0, 64'h0);
    push_req(chm_pkg::CMD_ADD, '1, '1, '1);
    push_req(chm_pkg::CMD_ADD, 64'h0, 32'h0, 64'h5a5a_a5a5_0f0f_f0f0);
    push_req(chm_pkg::CMD_GET, 64'h0, 32'h0, '1);
    push_req(chm_pkg::CMD_GET, '1, 32'h0, '0);
    push_req(chm_pkg::CMD_ADD, 64'h1234, 32'd61, 64'h77);
    push_req(chm_pkg::CMD_ITER, 64'h0, 32'h0, '0);
    push_req(chm_pkg::CMD_REMOVE, 64'h0, 32'h0, '0);
    push_req(chm_pkg::CMD_REMOVE, 64'h0, 32'h0, '0);
    push_req(chm_pkg::CMD_ADD, 64'h55, 32'd122, 64'h1);
    push_req(chm_pkg::CMD_ITER, '1, '1, '1);
    wait_idle();
    // Ignored while entries are stored.
    write_buckets(9'd3);
    drain_map();

    // A single bucket: chain to the full pool, update while full, reuse freed nodes.
    write_buckets(9'd0);
    burst_mode = 1;
    for (i = 0; i < 66; i++)
      push_req(chm_pkg::CMD_ADD, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
    wait_idle();
    burst_mode = 0;
    push_req(chm_pkg::CMD_ADD, node_key[5], node_hash[5], '1);
    push_req(chm_pkg::CMD_ITER, '0, '0, '0);
    push_req(chm_pkg::CMD_REMOVE, node_key[0], node_hash[0], '0);
    push_req(chm_pkg::CMD_REMOVE, node_key[40], node_hash[40], '0);
    push_req(chm_pkg::CMD_REMOVE, node_key[63], node_hash[63], '0);
    push_req(chm_pkg::CMD_GET, node_key[40], node_hash[40], '0);
    for (i = 0; i < 4; i++)
      push_req(chm_pkg::CMD_ADD, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
    push_req(chm_pkg::CMD_ITER, '0, '0, '0);
    wait_idle();
    drain_map();

    write_buckets(9'd511);
    new_pool();
    random_reqs(8);
    wait_idle();
    drain_map();

    write_buckets(9'd256);
    write_buckets(9'd1);
    new_pool();
    random_reqs(6);
    wait_idle();
    drain_map();

    write_buckets(9'($urandom_range(2, 255)));
    new_pool();
    burst_mode = 1;
    random_reqs(4);
    wait_idle();
    burst_mode = 0;
    random_reqs(6);
    wait_idle();

    if (failures == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/chm_pkg.sv
sv/chm_ram.sv
sv/chm_fifo.sv
sv/chm_front.sv
sv/chm_back.sv
sv/chained_hash_map_engine.sv
verif/testbench.sv
